// ===== design/four_channel_dma_address_engine_assert.svh =====
// ----------------------------------------------------------------------------
// DMA address engine assertion macros
// Concurrent assertion wrappers for the engine's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_DMA_ADDRESS_ENGINE_ASSERT_SVH
`define FOUR_CHANNEL_DMA_ADDRESS_ENGINE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define FCDMA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Check a property on every clock edge, reset included.
`define FCDMA_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== design/fcdma_pkg.sv =====
// ----------------------------------------------------------------------------
// DMA address engine package
// Types, control word layout, address limits and load helpers.
// ----------------------------------------------------------------------------
package fcdma_pkg;

   localparam int NUM_CHANNELS = 4;
   localparam int CH_W         = $clog2(NUM_CHANNELS);

   // Control word layout
   localparam int CTL_DSTEP_LSB  = 5;
   localparam int CTL_SSTEP_LSB  = 7;
   localparam int CTL_REPEAT_BIT = 9;
   localparam int CTL_WORD_BIT   = 10;
   localparam int CTL_TIMING_LSB = 12;
   localparam int CTL_IRQ_BIT    = 14;
   localparam int CTL_ENABLE_BIT = 15;

   // Special channels
   localparam logic [CH_W-1:0] NARROW_SRC_CH = CH_W'(0);
   localparam logic [CH_W-1:0] FIFO_CH_A     = CH_W'(1);
   localparam logic [CH_W-1:0] FIFO_CH_B     = CH_W'(2);
   localparam logic [CH_W-1:0] WIDE_CH       = CH_W'(3);

   // Address map and masks
   localparam logic [31:0] OPEN_BUS_LIMIT = 32'h0200_0000;
   localparam logic [31:0] CART_LO        = 32'h0800_0000;
   localparam logic [31:0] CART_HI        = 32'h0E00_0000;
   localparam logic [31:0] MASK_27        = 32'h07FF_FFFF;
   localparam logic [31:0] MASK_28        = 32'h0FFF_FFFF;

   // Unit counts
   localparam logic [16:0] COUNT_FULL      = 17'h0_4000;
   localparam logic [16:0] COUNT_FULL_WIDE = 17'h1_0000;
   localparam logic [16:0] FIFO_UNITS      = 17'd4;

   localparam logic [1:0] START_STALL = 2'd2;

   typedef enum logic [1:0] {
      REQ_WRITE  = 2'd0,
      REQ_VBLANK = 2'd1,
      REQ_HBLANK = 2'd2,
      REQ_XFER   = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      REG_SOURCE  = 2'd0,
      REG_DEST    = 2'd1,
      REG_COUNT   = 2'd2,
      REG_CONTROL = 2'd3
   } reg_code_type;

   typedef enum logic [1:0] {
      STEP_INC    = 2'd0,
      STEP_DEC    = 2'd1,
      STEP_FIXED  = 2'd2,
      STEP_RELOAD = 2'd3
   } step_code_type;

   typedef enum logic [1:0] {
      TIM_IMMEDIATE = 2'd0,
      TIM_VBLANK    = 2'd1,
      TIM_HBLANK    = 2'd2,
      TIM_SPECIAL   = 2'd3
   } timing_code_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [1:0]  chan_sel;
      logic [1:0]  reg_sel;
      logic [31:0] wr_value;
      logic [31:0] bus_read_value;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  xfer_channel;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic        word_size;
      logic        from_latch;
      logic        nonsequential;
      logic [31:0] store_value;
      logic        irq_raise;
      logic        run_done;
      logic [1:0]  start_stall;
   } rsp_item_type;

   typedef struct packed {
      logic [31:0] cur_source;
      logic [31:0] cur_dest;
      logic [16:0] unit_total;
      logic [16:0] unit_done;
      logic [15:0] run_control;
   } chan_run_type;

   typedef struct packed {
      logic        disarm;
      logic        clear_enable;
      logic        latch_write;
      logic [31:0] latch_value;
   } xfer_ctl_type;

   typedef struct packed {
      logic                    has_result;
      logic [NUM_CHANNELS-1:0] armed_mask;
   } core_status_type;

   function automatic logic [16:0] count_load(input logic [CH_W-1:0] ch,
                                              input logic [15:0] cnt);
      logic [16:0] n;
      if (ch == WIDE_CH) begin
         n = (cnt == 16'd0) ? COUNT_FULL_WIDE : {1'b0, cnt};
      end else begin
         n = (cnt[13:0] == 14'd0) ? COUNT_FULL : {3'b000, cnt[13:0]};
      end
      return n;
   endfunction

   function automatic logic [31:0] dest_load(input logic [CH_W-1:0] ch,
                                             input logic [31:0] dst);
      return dst & ((ch == WIDE_CH) ? MASK_28 : MASK_27);
   endfunction

   function automatic logic [31:0] src_load(input logic [CH_W-1:0] ch,
                                            input logic [31:0] src);
      return src & ((ch == NARROW_SRC_CH) ? MASK_27 : MASK_28);
   endfunction

   function automatic logic is_fifo(input logic [CH_W-1:0] ch, input logic [15:0] ctl);
      return (ctl[CTL_TIMING_LSB +: 2] == TIM_SPECIAL) &&
             ((ch == FIFO_CH_A) || (ch == FIFO_CH_B));
   endfunction

   function automatic logic [31:0] step_addr(input logic [31:0] addr,
                                             input logic [1:0] code,
                                             input logic [31:0] width);
      logic [31:0] r;
      case (code) inside
         STEP_INC, STEP_RELOAD: r = addr + width;
         STEP_DEC:              r = addr - width;
         default:               r = addr;
      endcase
      return r;
   endfunction

endpackage

// ===== design/fcdma_req_if.sv =====
// ----------------------------------------------------------------------------
// DMA request channel
// Valid/ready channel carrying one request beat.
// ----------------------------------------------------------------------------
interface fcdma_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [1:0]  chan_sel;
   logic [1:0]  reg_sel;
   logic [31:0] wr_value;
   logic [31:0] bus_read_value;

   modport source (output valid, req_type, chan_sel, reg_sel, wr_value, bus_read_value,
                   input ready);
   modport sink (input valid, req_type, chan_sel, reg_sel, wr_value, bus_read_value,
                 output ready);
endinterface

// ===== design/fcdma_rsp_if.sv =====
// ----------------------------------------------------------------------------
// DMA response channel
// Valid/ready channel carrying one transfer report beat.
// ----------------------------------------------------------------------------
interface fcdma_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  xfer_channel;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic        word_size;
   logic        from_latch;
   logic        nonsequential;
   logic [31:0] store_value;
   logic        irq_raise;
   logic        run_done;
   logic [1:0]  start_stall;

   modport source (output valid, xfer_channel, src_addr, dst_addr, word_size, from_latch,
                   nonsequential, store_value, irq_raise, run_done, start_stall,
                   input ready);
   modport sink (input valid, xfer_channel, src_addr, dst_addr, word_size, from_latch,
                 nonsequential, store_value, irq_raise, run_done, start_stall,
                 output ready);
endinterface

// ===== design/four_channel_dma_address_engine.sv =====
// ----------------------------------------------------------------------------
// Four-channel DMA address engine
// Register file, trigger arming and per-unit address stepping for four
// DMA channels, driven by request beats and reporting transfer beats.
// ----------------------------------------------------------------------------
// The engine takes one request beat per clock unless a held transfer report
// stalls it and, for a transfer request that finds an armed channel, presents
// one response beat through the response register. Each beat is held in an
// input register, handled in a single pass of channel logic (register write,
// trigger arming or one unit of transfer for the lowest armed channel) and, if
// it yields a report, lands in the response register. Register writes, vblank
// and hblank beats and transfers with nothing armed produce no response and
// never wait on the response side; a transfer report waits only while the
// previous report is still held. Channel state resets to zero, so requests are
// taken straight after reset. Sound-FIFO runs on channels 1 and 2, repeat
// reloads and the open-bus latch below the external work RAM are all handled
// inside the same pass.
module four_channel_dma_address_engine (
   input logic        clock,
   input logic        reset,
   fcdma_req_if.sink   req_chan,
   fcdma_rsp_if.source rsp_chan
);
   import fcdma_pkg::*;

`include "four_channel_dma_address_engine_assert.svh"

   logic            in_valid_ff;
   logic            in_valid_in;
   req_item_type    in_item_ff;
   req_item_type    in_item_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_item_type    rsp_item_ff;
   rsp_item_type    rsp_item_in;

   logic            advance;
   core_status_type status;
   rsp_item_type    core_result;

   // Advance the held beat unless it carries a report and the output is still full
   assign advance = in_valid_ff &&
                    (!status.has_result || !rsp_valid_ff || rsp_chan.ready);

   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_item_in.req_type       = req_chan.req_type;
      in_item_in.chan_sel       = req_chan.chan_sel;
      in_item_in.reg_sel        = req_chan.reg_sel;
      in_item_in.wr_value       = req_chan.wr_value;
      in_item_in.bus_read_value = req_chan.bus_read_value;

      // Hold the input register until its beat has been handled
      if (req_chan.valid && req_chan.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      // Drop a taken report, then load a fresh one
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_item_in  = rsp_item_ff;
      if (advance && status.has_result) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = core_result;
      end
   end

   fcdma_chan_ctrl u_chan_ctrl (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (in_item_ff),
      .status (status),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_item_ff <= in_item_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.xfer_channel  = rsp_item_ff.xfer_channel;
   assign rsp_chan.src_addr      = rsp_item_ff.src_addr;
   assign rsp_chan.dst_addr      = rsp_item_ff.dst_addr;
   assign rsp_chan.word_size     = rsp_item_ff.word_size;
   assign rsp_chan.from_latch    = rsp_item_ff.from_latch;
   assign rsp_chan.nonsequential = rsp_item_ff.nonsequential;
   assign rsp_chan.store_value   = rsp_item_ff.store_value;
   assign rsp_chan.irq_raise     = rsp_item_ff.irq_raise;
   assign rsp_chan.run_done      = rsp_item_ff.run_done;
   assign rsp_chan.start_stall   = rsp_item_ff.start_stall;

   // Non-transfer beats never report and must never stall
   `FCDMA_ASSERT(a_no_stall_silent, clock, reset,
                 (in_valid_ff && (in_item_ff.req_type != REQ_XFER)) |-> advance,
                 "silent beat stalled")
   // A reported channel is armed and has no lower armed neighbour
   `FCDMA_ASSERT(a_lowest_armed, clock, reset,
                 status.has_result |-> (status.armed_mask[core_result.xfer_channel] &&
                 ((status.armed_mask & ((4'b0001 << core_result.xfer_channel) - 4'b0001))
                  == 4'b0000)),
                 "serviced channel not lowest armed")
   // A finished run leaves its channel disarmed
   `FCDMA_ASSERT(a_done_disarms, clock, reset,
                 (advance && status.has_result && core_result.run_done) |=>
                 !status.armed_mask[$past(core_result.xfer_channel)],
                 "finished channel still armed")
   // Reset empties both registers
   `FCDMA_ASSERT_NORST(a_reset_empty, clock,
                       reset |=> (!in_valid_ff && !rsp_valid_ff),
                       "registers not empty after reset")

endmodule

// ===== design/fcdma_run_start.sv =====
// ----------------------------------------------------------------------------
// DMA run latch
// Builds a channel's run state when its enable bit rises.
// ----------------------------------------------------------------------------
module fcdma_run_start (
   input  logic [fcdma_pkg::CH_W-1:0] channel,
   input  logic [31:0]                reg_source,
   input  logic [31:0]                reg_dest,
   input  logic [15:0]                reg_count,
   input  logic [15:0]                control,
   output fcdma_pkg::chan_run_type    run,
   output logic                       arm_now
);
   import fcdma_pkg::*;

   logic        fifo;
   logic [15:0] ctl;
   logic [31:0] amask;

   always_comb begin
      fifo = is_fifo(channel, control);
      ctl  = control;
      // Sound FIFO: force fixed destination and word width
      if (fifo) begin
         ctl[CTL_DSTEP_LSB +: 2] = STEP_FIXED;
         ctl[CTL_WORD_BIT]       = 1'b1;
      end
      amask           = ctl[CTL_WORD_BIT] ? 32'd3 : 32'd1;
      run.cur_source  = src_load(channel, reg_source) & ~amask;
      run.cur_dest    = dest_load(channel, reg_dest) & ~amask;
      run.unit_total  = fifo ? FIFO_UNITS : count_load(channel, reg_count);
      run.unit_done   = '0;
      run.run_control = ctl;
      arm_now         = (ctl[CTL_TIMING_LSB +: 2] == TIM_IMMEDIATE);
   end

endmodule

// ===== design/fcdma_xfer.sv =====
// ----------------------------------------------------------------------------
// DMA unit transfer
// Reports one unit for a channel and works out its next run state.
// ----------------------------------------------------------------------------
module fcdma_xfer (
   input  logic [fcdma_pkg::CH_W-1:0] channel,
   input  fcdma_pkg::chan_run_type    run,
   input  logic [31:0]                reg_dest,
   input  logic [15:0]                reg_count,
   input  logic [31:0]                open_bus_latch,
   input  logic [31:0]                bus_read_value,
   output fcdma_pkg::rsp_item_type    result,
   output fcdma_pkg::chan_run_type    run_next,
   output fcdma_pkg::xfer_ctl_type    ctl_out
);
   import fcdma_pkg::*;

   logic        word;
   logic        first;
   logic        latch;
   logic        cart;
   logic        done;
   logic        reload_run;
   logic [1:0]  timing;
   logic [1:0]  sstep;
   logic [1:0]  dstep;
   logic [31:0] width;
   logic [31:0] amask;
   logic [16:0] done_count;

   always_comb begin
      word   = run.run_control[CTL_WORD_BIT];
      timing = run.run_control[CTL_TIMING_LSB +: 2];
      width  = word ? 32'd4 : 32'd2;
      amask  = word ? 32'd3 : 32'd1;
      first  = (run.unit_done == '0);
      latch  = (run.cur_source < OPEN_BUS_LIMIT);
      cart   = (run.cur_source >= CART_LO) && (run.cur_source < CART_HI);
      // Cartridge space always increments
      sstep  = cart ? STEP_INC : run.run_control[CTL_SSTEP_LSB +: 2];
      dstep  = run.run_control[CTL_DSTEP_LSB +: 2];

      done_count = run.unit_done + 17'd1;
      done       = (done_count >= run.unit_total);
      reload_run = run.run_control[CTL_REPEAT_BIT] && (timing != TIM_IMMEDIATE);

      run_next            = run;
      run_next.cur_source = step_addr(run.cur_source, sstep, width);
      run_next.cur_dest   = step_addr(run.cur_dest, dstep, width);
      run_next.unit_done  = done ? '0 : done_count;
      if (done && reload_run) begin
         run_next.unit_total = is_fifo(channel, run.run_control) ? FIFO_UNITS
                                                                 : count_load(channel, reg_count);
         if (dstep == STEP_RELOAD) begin
            run_next.cur_dest = dest_load(channel, reg_dest) & ~amask;
         end
      end

      ctl_out.disarm       = done;
      ctl_out.clear_enable = done && !reload_run;
      ctl_out.latch_write  = !latch;
      ctl_out.latch_value  = word ? bus_read_value
                                  : {bus_read_value[15:0], bus_read_value[15:0]};

      result.xfer_channel  = channel;
      result.src_addr      = run.cur_source;
      result.dst_addr      = run.cur_dest;
      result.word_size     = word;
      result.from_latch    = latch;
      result.nonsequential = first;
      if (latch) begin
         result.store_value = word ? open_bus_latch : {16'h0000, open_bus_latch[15:0]};
      end else begin
         result.store_value = word ? bus_read_value : {16'h0000, bus_read_value[15:0]};
      end
      result.irq_raise   = done && run.run_control[CTL_IRQ_BIT];
      result.run_done    = done;
      result.start_stall = (first && (timing == TIM_IMMEDIATE)) ? START_STALL : 2'd0;
   end

endmodule

// ===== design/fcdma_chan_ctrl.sv =====
// ----------------------------------------------------------------------------
// DMA channel control
// Channel registers, run state, arming and one pass per request beat.
// ----------------------------------------------------------------------------
module fcdma_chan_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  fcdma_pkg::req_item_type     item,
   output fcdma_pkg::core_status_type  status,
   output fcdma_pkg::rsp_item_type     result
);
   import fcdma_pkg::*;

   logic [31:0]             reg_source_ff  [NUM_CHANNELS];
   logic [31:0]             reg_source_in  [NUM_CHANNELS];
   logic [31:0]             reg_dest_ff    [NUM_CHANNELS];
   logic [31:0]             reg_dest_in    [NUM_CHANNELS];
   logic [15:0]             reg_count_ff   [NUM_CHANNELS];
   logic [15:0]             reg_count_in   [NUM_CHANNELS];
   logic [15:0]             reg_control_ff [NUM_CHANNELS];
   logic [15:0]             reg_control_in [NUM_CHANNELS];
   chan_run_type            run_ff         [NUM_CHANNELS];
   chan_run_type            run_in         [NUM_CHANNELS];
   logic [31:0]             latch_ff       [NUM_CHANNELS];
   logic [31:0]             latch_in       [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] armed_ff;
   logic [NUM_CHANNELS-1:0] armed_in;

   logic [CH_W-1:0] pick;
   logic [CH_W-1:0] idx;
   logic            any_armed;
   logic            is_xfer;
   logic [15:0]     new_ctl;
   chan_run_type    start_run;
   logic            start_arm;
   chan_run_type    xfer_run;
   xfer_ctl_type    xfer_ctl;

   // Lowest armed channel wins
   always_comb begin
      pick = '0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (armed_ff[i]) begin
            pick = CH_W'(i);
         end
      end
   end

   assign any_armed = |armed_ff;
   assign is_xfer   = (item.req_type == REQ_XFER);
   assign idx       = is_xfer ? pick : item.chan_sel;
   assign new_ctl   = item.wr_value[15:0];

   assign status.has_result = is_xfer && any_armed;
   assign status.armed_mask = armed_ff;

   fcdma_run_start u_run_start (
      .channel    (idx),
      .reg_source (reg_source_ff[idx]),
      .reg_dest   (reg_dest_ff[idx]),
      .reg_count  (reg_count_ff[idx]),
      .control    (new_ctl),
      .run        (start_run),
      .arm_now    (start_arm)
   );

   fcdma_xfer u_xfer (
      .channel        (idx),
      .run            (run_ff[idx]),
      .reg_dest       (reg_dest_ff[idx]),
      .reg_count      (reg_count_ff[idx]),
      .open_bus_latch (latch_ff[idx]),
      .bus_read_value (item.bus_read_value),
      .result         (result),
      .run_next       (xfer_run),
      .ctl_out        (xfer_ctl)
   );

   always_comb begin
      reg_source_in  = reg_source_ff;
      reg_dest_in    = reg_dest_ff;
      reg_count_in   = reg_count_ff;
      reg_control_in = reg_control_ff;
      run_in         = run_ff;
      latch_in       = latch_ff;
      armed_in       = armed_ff;
      if (fire) begin
         unique case (item.req_type) inside
            REQ_WRITE: begin
               unique case (item.reg_sel)
                  REG_SOURCE:  reg_source_in[idx] = item.wr_value;
                  REG_DEST:    reg_dest_in[idx]   = item.wr_value;
                  REG_COUNT:   reg_count_in[idx]  = item.wr_value[15:0];
                  REG_CONTROL: begin
                     reg_control_in[idx] = new_ctl;
                     if (new_ctl[CTL_ENABLE_BIT] && !reg_control_ff[idx][CTL_ENABLE_BIT]) begin
                        run_in[idx] = start_run;
                        if (start_arm) begin
                           armed_in[idx] = 1'b1;
                        end
                     end else if (!new_ctl[CTL_ENABLE_BIT] &&
                                  reg_control_ff[idx][CTL_ENABLE_BIT]) begin
                        armed_in[idx] = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
            REQ_VBLANK, REQ_HBLANK: begin
               for (int i = 0; i < NUM_CHANNELS; i++) begin
                  if (reg_control_ff[i][CTL_ENABLE_BIT] &&
                      (reg_control_ff[i][CTL_TIMING_LSB +: 2] == item.req_type)) begin
                     armed_in[i] = 1'b1;
                  end
               end
            end
            REQ_XFER: begin
               if (any_armed) begin
                  run_in[idx] = xfer_run;
                  if (xfer_ctl.latch_write) begin
                     latch_in[idx] = xfer_ctl.latch_value;
                  end
                  if (xfer_ctl.clear_enable) begin
                     reg_control_in[idx][CTL_ENABLE_BIT] = 1'b0;
                  end
                  if (xfer_ctl.disarm) begin
                     armed_in[idx] = 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            reg_source_ff[i]  <= '0;
            reg_dest_ff[i]    <= '0;
            reg_count_ff[i]   <= '0;
            reg_control_ff[i] <= '0;
            run_ff[i]         <= '0;
            latch_ff[i]       <= '0;
         end
         armed_ff <= '0;
      end else begin
         reg_source_ff  <= reg_source_in;
         reg_dest_ff    <= reg_dest_in;
         reg_count_ff   <= reg_count_in;
         reg_control_ff <= reg_control_in;
         run_ff         <= run_in;
         latch_ff       <= latch_in;
         armed_ff       <= armed_in;
      end
   end

endmodule
